[rtl/core/scdd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subchannel descriptor decode package
// Shared widths, the short form lookup table and the reciprocal constants
// used to divide the long form size by the small divisors of each level.
// ----------------------------------------------------------------------------
package scdd_pkg;

  localparam int unsigned InW     = 32;
  localparam int unsigned OutW    = 48;
  localparam int unsigned UserW   = 2;
  localparam int unsigned SizeW   = 10;
  localparam int unsigned RateW   = 12;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned BytesW  = 3;
  localparam int unsigned RecipW  = 15;
  localparam int unsigned RecipSh = 16;
  localparam int unsigned QuotW   = 8;
  localparam int unsigned ProdW   = SizeW + RecipW;

  localparam logic [2:0] OptEep = 3'd0;
  localparam logic [2:0] OptAlt = 3'd1;

  localparam logic [BytesW-1:0] BytesShort = 3'd3;
  localparam logic [BytesW-1:0] BytesLong  = 3'd4;

  typedef struct packed {
    logic [SizeW-1:0]  size;
    logic [LevelW-1:0] level;
    logic [RateW-1:0]  rate;
  } short_entry_t;

  function automatic short_entry_t short_lookup(input logic [5:0] idx);
    short_entry_t e;
    case (idx)
      6'd0:  e = '{10'd16,  3'd5, 12'd32};
      6'd1:  e = '{10'd21,  3'd4, 12'd32};
      6'd2:  e = '{10'd24,  3'd3, 12'd32};
      6'd3:  e = '{10'd29,  3'd2, 12'd32};
      6'd4:  e = '{10'd35,  3'd1, 12'd32};
      6'd5:  e = '{10'd24,  3'd5, 12'd48};
      6'd6:  e = '{10'd29,  3'd4, 12'd48};
      6'd7:  e = '{10'd35,  3'd3, 12'd48};
      6'd8:  e = '{10'd42,  3'd2, 12'd48};
      6'd9:  e = '{10'd52,  3'd1, 12'd48};
      6'd10: e = '{10'd29,  3'd5, 12'd56};
      6'd11: e = '{10'd35,  3'd4, 12'd56};
      6'd12: e = '{10'd42,  3'd3, 12'd56};
      6'd13: e = '{10'd52,  3'd2, 12'd56};
      6'd14: e = '{10'd32,  3'd5, 12'd64};
      6'd15: e = '{10'd42,  3'd4, 12'd64};
      6'd16: e = '{10'd48,  3'd3, 12'd64};
      6'd17: e = '{10'd58,  3'd2, 12'd64};
      6'd18: e = '{10'd70,  3'd1, 12'd64};
      6'd19: e = '{10'd40,  3'd5, 12'd80};
      6'd20: e = '{10'd52,  3'd4, 12'd80};
      6'd21: e = '{10'd58,  3'd3, 12'd80};
      6'd22: e = '{10'd70,  3'd2, 12'd80};
      6'd23: e = '{10'd84,  3'd1, 12'd80};
      6'd24: e = '{10'd48,  3'd5, 12'd96};
      6'd25: e = '{10'd58,  3'd4, 12'd96};
      6'd26: e = '{10'd70,  3'd3, 12'd96};
      6'd27: e = '{10'd84,  3'd2, 12'd96};
      6'd28: e = '{10'd104, 3'd1, 12'd96};
      6'd29: e = '{10'd58,  3'd5, 12'd112};
      6'd30: e = '{10'd70,  3'd4, 12'd112};
      6'd31: e = '{10'd84,  3'd3, 12'd112};
      6'd32: e = '{10'd104, 3'd2, 12'd112};
      6'd33: e = '{10'd64,  3'd5, 12'd128};
      6'd34: e = '{10'd84,  3'd4, 12'd128};
      6'd35: e = '{10'd96,  3'd3, 12'd128};
      6'd36: e = '{10'd116, 3'd2, 12'd128};
      6'd37: e = '{10'd140, 3'd1, 12'd128};
      6'd38: e = '{10'd80,  3'd5, 12'd160};
      6'd39: e = '{10'd104, 3'd4, 12'd160};
      6'd40: e = '{10'd116, 3'd3, 12'd160};
      6'd41: e = '{10'd140, 3'd2, 12'd160};
      6'd42: e = '{10'd168, 3'd1, 12'd160};
      6'd43: e = '{10'd96,  3'd5, 12'd192};
      6'd44: e = '{10'd116, 3'd4, 12'd192};
      6'd45: e = '{10'd140, 3'd3, 12'd192};
      6'd46: e = '{10'd168, 3'd2, 12'd192};
      6'd47: e = '{10'd208, 3'd1, 12'd192};
      6'd48: e = '{10'd116, 3'd5, 12'd224};
      6'd49: e = '{10'd140, 3'd4, 12'd224};
      6'd50: e = '{10'd168, 3'd3, 12'd224};
      6'd51: e = '{10'd208, 3'd2, 12'd224};
      6'd52: e = '{10'd232, 3'd1, 12'd224};
      6'd53: e = '{10'd128, 3'd5, 12'd256};
      6'd54: e = '{10'd168, 3'd4, 12'd256};
      6'd55: e = '{10'd192, 3'd3, 12'd256};
      6'd56: e = '{10'd232, 3'd2, 12'd256};
      6'd57: e = '{10'd280, 3'd1, 12'd256};
      6'd58: e = '{10'd160, 3'd5, 12'd320};
      6'd59: e = '{10'd208, 3'd4, 12'd320};
      6'd60: e = '{10'd280, 3'd2, 12'd320};
      6'd61: e = '{10'd192, 3'd5, 12'd384};
      6'd62: e = '{10'd280, 3'd3, 12'd384};
      6'd63: e = '{10'd416, 3'd1, 12'd384};
      default: e = '0;
    endcase
    return e;
  endfunction

  // Reciprocals are ceil(2^16 / divisor); exact for every 10-bit size.
  function automatic logic [RecipW-1:0] recip_lookup(input logic alt, input logic [1:0] lv);
    logic [RecipW-1:0] r;
    case ({alt, lv})
      3'b000:  r = 15'd5462;
      3'b001:  r = 15'd8192;
      3'b010:  r = 15'd10923;
      3'b011:  r = 15'd16384;
      3'b100:  r = 15'd2428;
      3'b101:  r = 15'd3121;
      3'b110:  r = 15'd3641;
      3'b111:  r = 15'd4370;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/subchannel_descriptor_decode_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subchannel descriptor decode
// Decodes one 32-bit subchannel organisation descriptor per beat into its
// identifier, start address, size, protection level and bit rate.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_*) carries one descriptor word per beat, first
// transmitted bit in bit 31. The output channel (out_*) carries one decoded
// record per input beat, in the same order.
// An accepted input beat passes through the input register, then the table
// lookup and the reciprocal multiply that divides the long form size, then
// the output register that drives out_tvalid.
// Throughput is one beat per cycle while the receiver does not stall; the
// single multiplier in the decode stage is the longest path.
// Reset clears both valid flags; the block is ready in the first cycle after
// reset is released. When the receiver stalls, the output register holds its
// beat, the input register fills, and in_tready then drops until the
// receiver takes a beat again.
// ----------------------------------------------------------------------------
module subchannel_descriptor_decode_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [31:0] descriptor_word
  input  logic [scdd_pkg::InW-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [5:0] subchannel_id, [15:6] start_address, [18:16] protection_level,
  // [28:19] size_units, [40:29] bit_rate, [43:41] descriptor_bytes, [47:44] zero
  output logic [scdd_pkg::OutW-1:0]   out_tdata,
  // [0] short_form, [1] record_valid
  output logic [scdd_pkg::UserW-1:0]  out_tuser
);

  logic                       s1_valid_r, s1_valid_nxt;
  logic [scdd_pkg::InW-1:0]   word_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [scdd_pkg::OutW-1:0]  data_r, data_nxt;
  logic [scdd_pkg::UserW-1:0] user_r, user_nxt;
  logic                       s2_ld;
  logic                       in_acc;

  scdd_pkg::short_entry_t          sh;
  logic [2:0]                      opt;
  logic [1:0]                      lv;
  logic [scdd_pkg::SizeW-1:0]      sz;
  logic [scdd_pkg::RecipW-1:0]     recip;
  logic [scdd_pkg::ProdW-1:0]      prod;
  logic [scdd_pkg::QuotW-1:0]      quot;
  logic [scdd_pkg::LevelW-1:0]     level;
  logic [scdd_pkg::SizeW-1:0]      size;
  logic [scdd_pkg::RateW-1:0]      rate;
  logic [scdd_pkg::BytesW-1:0]     nbytes;
  logic                            is_short;
  logic                            rec_valid;

  assign s2_ld     = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ld;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s2_ld ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s2_ld ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      word_r <= in_tdata;
    end
    if (s2_ld && s1_valid_r) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
    end
  end

  assign sh    = scdd_pkg::short_lookup(word_r[13:8]);
  assign opt   = word_r[14:12];
  assign lv    = word_r[11:10];
  assign sz    = word_r[9:0];
  assign recip = scdd_pkg::recip_lookup(opt == scdd_pkg::OptAlt, lv);
  assign prod  = sz * recip;
  assign quot  = prod[scdd_pkg::RecipSh +: scdd_pkg::QuotW];

  always_comb begin
    is_short  = 1'b0;
    rec_valid = 1'b1;
    level     = '0;
    size      = '0;
    rate      = '0;
    nbytes    = scdd_pkg::BytesLong;
    if (!word_r[15]) begin
      is_short = 1'b1;
      level    = sh.level;
      size     = sh.size;
      rate     = sh.rate;
      nbytes   = scdd_pkg::BytesShort;
    end else if (opt == scdd_pkg::OptEep) begin
      level = {1'b0, lv};
      size  = sz;
      rate  = {1'b0, quot, 3'b000};
    end else if (opt == scdd_pkg::OptAlt) begin
      level = {1'b1, lv};
      size  = sz;
      rate  = {quot[6:0], 5'b00000};
    end else begin
      rec_valid = 1'b0;
    end
  end

  assign data_nxt = {4'b0000, nbytes, rate, size, level, word_r[25:16], word_r[31:26]};
  assign user_nxt = {rec_valid, is_short};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

`ifndef SYNTHESIS
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("in_tready low while the pipeline has room");

  a_id_follows_word: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ld) |=> (out_tvalid && out_tdata[5:0] == $past(word_r[31:26])))
    else $error("decoded identifier does not match the staged word");

  a_invalid_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |-> (out_tdata[40:16] == '0 && !out_tuser[0]))
    else $error("invalid record carries nonzero fields");

  a_short_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata[43:41] == scdd_pkg::BytesShort && out_tdata[18:16] != 3'd0 && out_tuser[1]))
    else $error("short form record has wrong length or level");
`endif

endmodule

[tb/subchannel_descriptor_decode_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subchannel descriptor decode testbench
// Streams descriptor words into the decoder, a short directed table first and
// then randomly shaped short and long form descriptors. Every decoded record
// is compared field by field against a hand-written record or a behavioral
// decoder kept in this file, in order, while both stream sides idle at random
// and the receiver at one point holds off long enough to back the input up.
// ----------------------------------------------------------------------------
module subchannel_descriptor_decode_top_tb;

  typedef struct packed {
    logic [5:0]                  subchannel_id;
    logic [9:0]                  start_address;
    logic                        short_form;
    logic [scdd_pkg::LevelW-1:0] protection_level;
    logic [scdd_pkg::SizeW-1:0]  size_units;
    logic [scdd_pkg::RateW-1:0]  bit_rate;
    logic [scdd_pkg::BytesW-1:0] descriptor_bytes;
    logic                        record_valid;
  } subch_record_t;

  typedef struct packed {
    logic [scdd_pkg::InW-1:0] word;
    logic                     known;
    subch_record_t            rec;
  } descriptor_row_t;

  localparam int unsigned NumDirected  = 24;
  localparam int unsigned NumRandom    = 950;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned DrainLimit   = 2000;
  localparam int unsigned MaxReports   = 10;

  // Short form table: size in capacity units, protection level, kbit/s.
  localparam int unsigned ShortTable [64][3] = '{
    '{16,5,32}, '{21,4,32}, '{24,3,32}, '{29,2,32}, '{35,1,32},
    '{24,5,48}, '{29,4,48}, '{35,3,48}, '{42,2,48}, '{52,1,48},
    '{29,5,56}, '{35,4,56}, '{42,3,56}, '{52,2,56},
    '{32,5,64}, '{42,4,64}, '{48,3,64}, '{58,2,64}, '{70,1,64},
    '{40,5,80}, '{52,4,80}, '{58,3,80}, '{70,2,80}, '{84,1,80},
    '{48,5,96}, '{58,4,96}, '{70,3,96}, '{84,2,96}, '{104,1,96},
    '{58,5,112}, '{70,4,112}, '{84,3,112}, '{104,2,112},
    '{64,5,128}, '{84,4,128}, '{96,3,128}, '{116,2,128}, '{140,1,128},
    '{80,5,160}, '{104,4,160}, '{116,3,160}, '{140,2,160}, '{168,1,160},
    '{96,5,192}, '{116,4,192}, '{140,3,192}, '{168,2,192}, '{208,1,192},
    '{116,5,224}, '{140,4,224}, '{168,3,224}, '{208,2,224}, '{232,1,224},
    '{128,5,256}, '{168,4,256}, '{192,3,256}, '{232,2,256}, '{280,1,256},
    '{160,5,320}, '{208,4,320}, '{280,2,320},
    '{192,5,384}, '{280,3,384}, '{416,1,384}
  };

  localparam int unsigned EepDivisor [4] = '{12, 8, 6, 4};
  localparam int unsigned AltDivisor [4] = '{27, 21, 18, 15};

  localparam descriptor_row_t DirectedRows [NumDirected] = '{
    '{32'h0000_0000, 1'b1,
      '{6'd0,  10'd0,    1'b1, 3'd5, 10'd16,   12'd32,   scdd_pkg::BytesShort, 1'b1}},
    '{32'hFFFF_FFFF, 1'b1,
      '{6'd63, 10'd1023, 1'b0, 3'd0, 10'd0,    12'd0,    scdd_pkg::BytesLong,  1'b0}},
    '{32'hFC00_3F00, 1'b1,
      '{6'd63, 10'd0,    1'b1, 3'd1, 10'd416,  12'd384,  scdd_pkg::BytesShort, 1'b1}},
    '{32'h03FF_40FF, 1'b1,
      '{6'd0,  10'd1023, 1'b1, 3'd5, 10'd16,   12'd32,   scdd_pkg::BytesShort, 1'b1}},
    '{32'h0000_8000, 1'b1,
      '{6'd0,  10'd0,    1'b0, 3'd0, 10'd0,    12'd0,    scdd_pkg::BytesLong,  1'b1}},
    '{32'h0000_9FFF, 1'b1,
      '{6'd0,  10'd0,    1'b0, 3'd7, 10'd1023, 12'd2176, scdd_pkg::BytesLong,  1'b1}},
    '{32'h0000_83FF, 1'b0, '0},
    '{32'h0000_87FF, 1'b0, '0},
    '{32'h0000_8BFF, 1'b0, '0},
    '{32'h0000_8FFF, 1'b0, '0},
    '{32'h0000_93FF, 1'b0, '0},
    '{32'h0000_97FF, 1'b0, '0},
    '{32'h0000_9BFF, 1'b0, '0},
    '{32'h0000_800B, 1'b0, '0},
    '{32'h0000_901A, 1'b0, '0},
    '{32'h0000_901B, 1'b0, '0},
    '{32'h0400_A123, 1'b0, '0},
    '{32'h0801_B456, 1'b0, '0},
    '{32'h0C02_C789, 1'b0, '0},
    '{32'h1003_DABC, 1'b0, '0},
    '{32'h1404_E3DE, 1'b0, '0},
    '{32'h1805_F0F0, 1'b0, '0},
    '{32'h5555_2A00, 1'b0, '0},
    '{32'hAAAA_157F, 1'b0, '0}
  };

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [scdd_pkg::InW-1:0]   in_tdata   = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [scdd_pkg::OutW-1:0]  out_tdata;
  logic [scdd_pkg::UserW-1:0] out_tuser;

  subch_record_t pending_records [$];
  int unsigned   error_count   = 0;
  int unsigned   records_seen  = 0;
  int unsigned   hold_request  = 0;
  bit            send_burst    = 1'b0;

  subchannel_descriptor_decode_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever begin
      #4 clk = ~clk;
    end
  end

  initial begin
    #2_000_000;
    $display("subchannel_descriptor_decode_top_tb: errors");
    $finish;
  end

  function automatic subch_record_t decode_descriptor(input logic [scdd_pkg::InW-1:0] w);
    subch_record_t r;
    int unsigned   idx;
    int unsigned   sz;
    logic [2:0]    opt;
    logic [1:0]    lv;
    r = '0;
    r.subchannel_id = w[31:26];
    r.start_address = w[25:16];
    r.record_valid  = 1'b1;
    if (!w[15]) begin
      idx = 32'(w[13:8]);
      r.short_form       = 1'b1;
      r.size_units       = scdd_pkg::SizeW'(ShortTable[idx][0]);
      r.protection_level = scdd_pkg::LevelW'(ShortTable[idx][1]);
      r.bit_rate         = scdd_pkg::RateW'(ShortTable[idx][2]);
      r.descriptor_bytes = scdd_pkg::BytesShort;
    end else begin
      opt = w[14:12];
      lv  = w[11:10];
      sz  = 32'(w[9:0]);
      r.descriptor_bytes = scdd_pkg::BytesLong;
      if (opt == scdd_pkg::OptEep) begin
        r.protection_level = {1'b0, lv};
        r.size_units       = scdd_pkg::SizeW'(sz);
        r.bit_rate         = scdd_pkg::RateW'((sz / EepDivisor[lv]) * 8);
      end else if (opt == scdd_pkg::OptAlt) begin
        r.protection_level = {1'b1, lv};
        r.size_units       = scdd_pkg::SizeW'(sz);
        r.bit_rate         = scdd_pkg::RateW'((sz / AltDivisor[lv]) * 32);
      end else begin
        r.record_valid = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic string record_text(input subch_record_t r);
    return $sformatf("id=%0d addr=%0d short=%0d lvl=%0d size=%0d rate=%0d bytes=%0d valid=%0d",
                     r.subchannel_id, r.start_address, r.short_form, r.protection_level,
                     r.size_units, r.bit_rate, r.descriptor_bytes, r.record_valid);
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MaxReports) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  function automatic logic [scdd_pkg::InW-1:0] random_descriptor();
    logic [scdd_pkg::InW-1:0] w;
    int unsigned              pick;
    w    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      w[15] = 1'b0;
    end else if (pick < 80) begin
      w[15]    = 1'b1;
      w[14:12] = $urandom_range(0, 1) ? scdd_pkg::OptAlt : scdd_pkg::OptEep;
      case ($urandom_range(0, 9))
        0:       w[9:0] = '0;
        1:       w[9:0] = '1;
        default: w[9:0] = 10'($urandom_range(0, 1023));
      endcase
    end else if (pick < 92) begin
      w[15]    = 1'b1;
      w[14:12] = 3'($urandom_range(2, 7));
    end
    return w;
  endfunction

  // Offers one beat; returns at the edge where it is accepted.
  task automatic send_descriptor(input logic [scdd_pkg::InW-1:0] w, input subch_record_t rec);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(negedge clk); while (!in_tready);
    pending_records.push_back(rec);
    @(posedge clk);
  endtask

  initial begin
    subch_record_t act;
    subch_record_t exp_rec;
    logic [3:0]    pad;
    int unsigned   stall;
    bit            quiet;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      quiet = ((records_seen / 80) % 3) == 2;
      stall = (hold_request > 0) ? hold_request : (quiet ? 0 : $urandom_range(0, 6));
      hold_request = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_tvalid);
      act.subchannel_id    = out_tdata[5:0];
      act.start_address    = out_tdata[15:6];
      act.protection_level = out_tdata[18:16];
      act.size_units       = out_tdata[28:19];
      act.bit_rate         = out_tdata[40:29];
      act.descriptor_bytes = out_tdata[43:41];
      act.short_form       = out_tuser[0];
      act.record_valid     = out_tuser[1];
      pad                  = out_tdata[47:44];
      @(posedge clk);
      records_seen++;
      if (pending_records.size() == 0) begin
        flag_error({"unexpected record: ", record_text(act)});
      end else begin
        exp_rec = pending_records.pop_front();
        if (act.subchannel_id !== exp_rec.subchannel_id ||
            act.start_address !== exp_rec.start_address ||
            act.short_form !== exp_rec.short_form ||
            act.protection_level !== exp_rec.protection_level ||
            act.size_units !== exp_rec.size_units ||
            act.bit_rate !== exp_rec.bit_rate ||
            act.descriptor_bytes !== exp_rec.descriptor_bytes ||
            act.record_valid !== exp_rec.record_valid ||
            pad !== 4'd0) begin
          flag_error({"mismatch\n  expected ", record_text(exp_rec),
                      "\n  actual   ", record_text(act), $sformatf(" pad=%0h", pad)});
        end
      end
    end
  end

  initial begin
    logic [scdd_pkg::InW-1:0] w;
    int unsigned              drain;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDirected; i++) begin
      send_descriptor(DirectedRows[i].word,
                      DirectedRows[i].known ? DirectedRows[i].rec
                                            : decode_descriptor(DirectedRows[i].word));
    end

    for (int i = 0; i < NumRandom; i++) begin
      send_burst = ((i / 100) % 3) == 1;
      if (i == 100) begin
        hold_request = HoldCycles;
      end
      if (i == 600) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_records.size() != 0) @(posedge clk);
      end
      w = random_descriptor();
      send_descriptor(w, decode_descriptor(w));
    end
    in_tvalid <= 1'b0;

    drain = 0;
    while (pending_records.size() != 0 && drain < DrainLimit) begin
      @(posedge clk);
      drain++;
    end
    if (pending_records.size() != 0) begin
      flag_error($sformatf("%0d records never arrived", pending_records.size()));
    end
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("subchannel_descriptor_decode_top_tb: clean");
    end else begin
      $display("subchannel_descriptor_decode_top_tb: errors");
    end
    $finish;
  end

endmodule
